[design/cbsc_pkg.sv]
// Shared types and constants for the cut-cell boundary stencil coefficient block.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package cbsc_pkg;

  localparam int PW     = 17;   // wall fraction width
  localparam int GW     = 24;   // grid spacing register width
  localparam int IDX_W  = 3;    // coefficient index width
  localparam int NSLOT  = 10;   // most coefficients one item produces
  localparam int SLOT_W = 4;    // index into the coefficient slots

  localparam logic GROUP_STENCIL = 1'b0;
  localparam logic GROUP_FLUX    = 1'b1;

  localparam logic [GW-1:0] SPACING_RESET = GW'(65536);

  typedef enum logic [1:0] {
    KIND_FLOAT     = 2'd0,
    KIND_DIRICHLET = 2'd1,
    KIND_NEUMANN   = 2'd2,
    KIND_UNUSED    = 2'd3
  } kind_t;

  // How a base value is formed from its numerator.
  typedef enum logic [1:0] {
    OP_PASS = 2'd0,
    OP_HALF = 2'd1,
    OP_DIV  = 2'd2
  } op_t;

  // Which of the three rational denominators a division uses.
  typedef enum logic [1:0] {
    DEN_A = 2'd0,   // 2E + 3psi + psi^2
    DEN_B = 2'd1,   // E + psi
    DEN_C = 2'd2    // 2E + psi
  } den_t;

  typedef struct packed {
    logic             group;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             neg;
  } meta_t;

  function automatic int imax(int a, int b);
    return (a > b) ? a : b;
  endfunction

endpackage

[design/cut_cell_boundary_stencil_coeffs.sv]
// Top level of the cut-cell boundary stencil coefficient block.
// Uses cbsc_pkg, cbsc_front, cbsc_seq, cbsc_div and cbsc_outbuf.
`timescale 1ns / 1ps

// Usage. Each transaction on the slave stream carries one wall fraction psi and
// a boundary kind and side; the master stream returns its coefficients one per
// transaction: eight for a floating boundary, four for Dirichlet, ten for
// Neumann (eight stencil, two flux), none for the unused kind. tlast marks the
// final coefficient of each item. The grid spacing is written through cfg_we and
// cfg_wdata while the block is idle.
// From the accepting edge to the first coefficient, an item passes three front
// stages, two in the sequencer, the base divider (one quotient bit per stage
// plus rounding), the scaling divider and the output buffer. VW, the base value
// width, is 40 at the default parameters.
// Throughput is one coefficient per cycle while the output buffer has room;
// the sequencer issuing one division job per cycle sets that rate, and it takes
// a new item as the last job of the previous one issues. An unused-kind item
// yields none. Reset clears all valid bits and the output buffer and sets the
// spacing to 1.0. When the receiver stalls, the two-entry output buffer fills and
// then the whole pipeline holds; nothing is lost or repeated, and the slave side
// keeps accepting until the front stages are full.

module cut_cell_boundary_stencil_coeffs
  import cbsc_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int COEF_WIDTH = 48,
  localparam int TDW = ((COEF_WIDTH + IDX_W + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [GW-1:0]  cfg_wdata,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [23:0]    s_tdata,   // [16:0] wall_fraction
  input  logic [2:0]     s_tuser,   // [1:0] boundary_kind, [2] right_side
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [TDW-1:0] m_tdata,   // [COEF_WIDTH-1:0] coef_value, then coef_index
  output logic [1:0]     m_tuser,   // [0] coef_group, [1] saturated
  output logic           m_tlast
);

  // Width of signed base values; covers every numerator and denominator.
  localparam int MX  = imax(imax(2 * FRAC_BITS, PW + FRAC_BITS),
                            imax(2 * PW, 3 * PW - FRAC_BITS));
  localparam int VW  = MX + 5;
  localparam int CW3 = 3 * PW - FRAC_BITS;
  localparam int AW1 = VW - 1 + 2 * FRAC_BITS;
  localparam int AW2 = VW + FRAC_BITS + 1;
  localparam int QB2 = VW + FRAC_BITS;
  localparam int DW2 = 2 * GW;

  // Spacing register; zero is treated as the smallest spacing.
  logic [GW-1:0]  spacing;
  logic [GW-1:0]  gz;
  logic [DW2-1:0] g2;

  always_ff @(posedge clk) begin
    if (rst) spacing <= SPACING_RESET;
    else if (cfg_we) spacing <= cfg_wdata;
    g2 <= DW2'(gz) * DW2'(gz);
  end
  assign gz = (spacing == '0) ? GW'(1) : spacing;

  // Pipeline advance: the whole back end moves whenever the output buffer
  // has room, which is decided from registered state only.
  logic en;

  logic            f_valid, f_ready, f_right;
  logic [PW-1:0]   f_p;
  logic [2*PW-1:0] f_sq;
  logic [CW3-1:0]  f_cube;
  kind_t           f_kind;

  cbsc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_frac  (s_tdata[PW-1:0]),
    .in_kind  (kind_t'(s_tuser[1:0])),
    .in_right (s_tuser[2]),
    .out_valid(f_valid),
    .out_ready(f_ready),
    .out_p    (f_p),
    .out_sq   (f_sq),
    .out_cube (f_cube),
    .out_kind (f_kind),
    .out_right(f_right)
  );

  logic           j_valid;
  logic [AW1-1:0] j_dvd;
  logic [VW-1:0]  j_dvs;
  meta_t          j_meta;

  cbsc_seq #(.FRAC_BITS(FRAC_BITS), .VW(VW)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (f_valid),
    .in_ready    (f_ready),
    .in_p        (f_p),
    .in_sq       (f_sq),
    .in_cube     (f_cube),
    .in_kind     (f_kind),
    .in_right    (f_right),
    .out_valid   (j_valid),
    .out_dividend(j_dvd),
    .out_divisor (j_dvs),
    .out_meta    (j_meta)
  );

  // First division: the base value magnitude (quotient, halving or pass).
  logic          b_valid;
  logic [VW-1:0] b_quot;
  meta_t         b_meta;

  cbsc_div #(.AW(AW1), .DW(VW), .QB(VW - 1)) u_base_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (j_valid),
    .in_dividend(j_dvd),
    .in_divisor (j_dvs),
    .in_meta    (j_meta),
    .out_valid  (b_valid),
    .out_quot   (b_quot),
    .out_meta   (b_meta)
  );

  // Second division: stencil values by h*h with FRAC_BITS of scaling, flux by h.
  logic [AW2-1:0] s_dvd;
  logic [DW2-1:0] s_dvs;

  always_comb begin
    if (b_meta.group == GROUP_FLUX) begin
      s_dvd = AW2'(b_quot);
      s_dvs = DW2'(gz);
    end else begin
      s_dvd = AW2'({b_quot, {FRAC_BITS{1'b0}}});
      s_dvs = g2;
    end
  end

  logic         c_valid;
  logic [QB2:0] c_quot;
  meta_t        c_meta;

  cbsc_div #(.AW(AW2), .DW(DW2), .QB(QB2)) u_scale_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (b_valid),
    .in_dividend(s_dvd),
    .in_divisor (s_dvs),
    .in_meta    (b_meta),
    .out_valid  (c_valid),
    .out_quot   (c_quot),
    .out_meta   (c_meta)
  );

  logic [COEF_WIDTH-1:0] o_value;
  logic [IDX_W-1:0]      o_idx;
  logic                  o_group, o_sat;

  cbsc_outbuf #(.CW(COEF_WIDTH), .QW(QB2 + 1)) u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .space    (en),
    .in_valid (c_valid),
    .in_quot  (c_quot),
    .in_meta  (c_meta),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_value(o_value),
    .out_group(o_group),
    .out_idx  (o_idx),
    .out_sat  (o_sat),
    .out_last (m_tlast)
  );

  assign m_tdata = TDW'({o_idx, o_value});
  assign m_tuser = {o_sat, o_group};

endmodule

[design/cbsc_front.sv]
// Front pipeline: registers the input item and forms psi^2 and the rounded psi^3.
// Elastic three-stage pipeline; depends on cbsc_pkg.
`timescale 1ns / 1ps

module cbsc_front
  import cbsc_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  localparam int CW3 = 3 * PW - FRAC_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [PW-1:0]   in_frac,
  input  kind_t           in_kind,
  input  logic            in_right,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [PW-1:0]   out_p,
  output logic [2*PW-1:0] out_sq,
  output logic [CW3-1:0]  out_cube,
  output kind_t           out_kind,
  output logic            out_right
);

  logic v1, v2, v3;
  logic r1, r2, r3;
  logic [PW-1:0] p1, p2, p3;
  kind_t k1, k2, k3;
  logic rt1, rt2, rt3;
  logic [2*PW-1:0] sq2, sq3;
  logic [CW3-1:0] cb3;
  logic [3*PW-1:0] prod;

  assign r3 = ~v3 | out_ready;
  assign r2 = ~v2 | r3;
  assign r1 = ~v1 | r2;
  assign in_ready = r1;

  // Cube with half-up rounding back to 2*FRAC_BITS fraction bits.
  assign prod = (3 * PW)'(sq2) * (3 * PW)'(p2) + ((3 * PW)'(1) << (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
    if (r1 && in_valid) begin
      p1  <= in_frac;
      k1  <= in_kind;
      rt1 <= in_right;
    end
    if (r2 && v1) begin
      p2  <= p1;
      k2  <= k1;
      rt2 <= rt1;
      sq2 <= (2 * PW)'(p1) * (2 * PW)'(p1);
    end
    if (r3 && v2) begin
      p3  <= p2;
      k3  <= k2;
      rt3 <= rt2;
      sq3 <= sq2;
      cb3 <= prod[3*PW-1:FRAC_BITS];
    end
  end

  assign out_valid = v3;
  assign out_p     = p3;
  assign out_sq    = sq3;
  assign out_cube  = cb3;
  assign out_kind  = k3;
  assign out_right = rt3;

endmodule

[design/cbsc_seq.sv]
// Coefficient sequencer: builds the numerator list of one item in output order
// and issues one division job per cycle while en is high. Depends on cbsc_pkg.
`timescale 1ns / 1ps

module cbsc_seq
  import cbsc_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int VW = 40,
  localparam int CW3 = 3 * PW - FRAC_BITS,
  localparam int AW  = VW - 1 + 2 * FRAC_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [PW-1:0]   in_p,
  input  logic [2*PW-1:0] in_sq,
  input  logic [CW3-1:0]  in_cube,
  input  kind_t           in_kind,
  input  logic            in_right,
  output logic            out_valid,
  output logic [AW-1:0]   out_dividend,
  output logic [VW-1:0]   out_divisor,
  output meta_t           out_meta
);

  localparam logic signed [VW-1:0] E_VAL = VW'(1) << (2 * FRAC_BITS);

  logic signed [VW-1:0] e, s2, s3;
  logic signed [VW-1:0] fnum [8];
  op_t                  fop  [8];
  den_t                 fden [8];
  logic signed [VW-1:0] nnum [8];
  op_t                  nop  [8];
  den_t                 nden [8];
  logic signed [VW-1:0] xnum [2];
  logic signed [VW-1:0] bnum [NSLOT];
  op_t                  bop  [NSLOT];
  den_t                 bden [NSLOT];
  logic [SLOT_W-1:0]    bcount;
  logic [VW-1:0]        da, db, dc;

  logic signed [VW-1:0] num_q [NSLOT];
  op_t                  op_q  [NSLOT];
  den_t                 den_q [NSLOT];
  logic [VW-1:0]        da_q, db_q, dc_q;
  logic [SLOT_W-1:0]    n_q, i_q;
  logic                 busy;
  logic                 at_end, load;

  logic signed [VW-1:0] cur;
  logic                 cur_neg;
  logic [VW-2:0]        mag;
  logic [AW-1:0]        dvd;
  logic [VW-1:0]        dvs;

  always_comb begin
    logic [2:0] src;
    e  = VW'({in_p, {FRAC_BITS{1'b0}}});
    s2 = VW'(in_sq);
    s3 = VW'(in_cube);

    // Floating set.
    fnum[0] = e;                                            fop[0] = OP_PASS;
    fnum[1] = (E_VAL <<< 1) - (e <<< 1) - (s2 + (s2 <<< 1)) - s3;
    fop[1]  = OP_HALF;
    fnum[2] = (s2 <<< 1) + s3 - (E_VAL <<< 1);              fop[2] = OP_PASS;
    fnum[3] = (E_VAL <<< 1) - s2 - s3;                      fop[3] = OP_HALF;
    fnum[4] = (E_VAL <<< 1) + (e <<< 2);                    fop[4] = OP_DIV;
    fnum[5] = -(e <<< 1);                                   fop[5] = OP_PASS;
    fnum[6] = (s2 <<< 2) - (E_VAL <<< 1);                   fop[6] = OP_DIV;
    fnum[7] = (E_VAL <<< 1) - (s2 <<< 1);                   fop[7] = OP_DIV;
    for (int k = 0; k < 8; k++) fden[k] = DEN_A;
    fden[6] = DEN_B;
    fden[7] = DEN_C;

    // Neumann set; negated quotients carry the sign in the numerator.
    nnum[0] = -((E_VAL <<< 2) + (e <<< 3));                 nop[0] = OP_DIV;
    nnum[1] = e <<< 1;                                      nop[1] = OP_PASS;
    nnum[2] = (E_VAL <<< 1) + (e <<< 1) - (s2 <<< 2);       nop[2] = OP_DIV;
    nnum[3] = (s2 <<< 1) - (e <<< 1);                       nop[3] = OP_DIV;
    nnum[4] = e;                                            nop[4] = OP_PASS;
    nnum[5] = s2 - s3 - (E_VAL <<< 2);                      nop[5] = OP_HALF;
    nnum[6] = (E_VAL <<< 1) + s3 - (s2 <<< 1);              nop[6] = OP_PASS;
    nnum[7] = s3 + (s2 <<< 1) + s2 - (e <<< 1) - s3 - s3;   nop[7] = OP_HALF;
    for (int k = 0; k < 8; k++) nden[k] = DEN_A;
    nden[2] = DEN_B;
    nden[3] = DEN_C;

    xnum[0] = -(E_VAL <<< 1);
    xnum[1] = (e <<< 1) - (E_VAL <<< 1);

    for (int i = 0; i < 8; i++) begin
      if (in_right) src = 3'(7 - i);
      else if (in_kind == KIND_DIRICHLET) src = 3'(i + 4);
      else src = 3'(i);
      if (in_kind == KIND_NEUMANN) begin
        bnum[i] = nnum[src];
        bop[i]  = nop[src];
        bden[i] = nden[src];
      end else begin
        bnum[i] = fnum[src];
        bop[i]  = fop[src];
        bden[i] = fden[src];
      end
    end
    // Flux pair: on the right side reversed and negated.
    bnum[8] = in_right ? -xnum[1] : xnum[0];
    bnum[9] = in_right ? -xnum[0] : xnum[1];
    bop[8]  = OP_PASS;
    bop[9]  = OP_PASS;
    bden[8] = DEN_A;
    bden[9] = DEN_A;

    case (in_kind)
      KIND_FLOAT:     bcount = SLOT_W'(8);
      KIND_DIRICHLET: bcount = SLOT_W'(4);
      KIND_NEUMANN:   bcount = SLOT_W'(NSLOT);
      default:        bcount = '0;
    endcase

    da = (E_VAL <<< 1) + e + (e <<< 1) + s2;
    db = E_VAL + e;
    dc = (E_VAL <<< 1) + e;
  end

  assign at_end   = (i_q == n_q - SLOT_W'(1));
  assign in_ready = en & (~busy | at_end);
  assign load     = in_ready & in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= busy;
      if (load) busy <= (bcount != '0);
      else if (busy && at_end) busy <= 1'b0;
    end
    if (en && busy && !load) i_q <= i_q + SLOT_W'(1);
    if (load) begin
      i_q  <= '0;
      n_q  <= bcount;
      da_q <= da;
      db_q <= db;
      dc_q <= dc;
      for (int k = 0; k < NSLOT; k++) begin
        num_q[k] <= bnum[k];
        op_q[k]  <= bop[k];
        den_q[k] <= bden[k];
      end
    end
    if (en) begin
      out_dividend    <= dvd;
      out_divisor     <= dvs;
      out_meta.group  <= i_q[3];
      out_meta.idx    <= i_q[IDX_W-1:0];
      out_meta.last   <= at_end;
      out_meta.neg    <= cur_neg;
    end
  end

  always_comb begin
    cur     = num_q[i_q];
    cur_neg = cur[VW-1];
    mag     = (VW - 1)'(cur_neg ? -cur : cur);
    case (op_q[i_q])
      OP_DIV: begin
        dvd = {mag, {(2 * FRAC_BITS){1'b0}}};
        case (den_q[i_q])
          DEN_A:   dvs = da_q;
          DEN_B:   dvs = db_q;
          default: dvs = dc_q;
        endcase
      end
      OP_HALF: begin
        dvd = AW'(mag);
        dvs = VW'(2);
      end
      default: begin
        dvd = AW'(mag);
        dvs = VW'(1);
      end
    endcase
  end

endmodule

[design/cbsc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, round half up at the end.
// Quotient must fit QB bits before rounding. Depends on cbsc_pkg for meta_t.
`timescale 1ns / 1ps

module cbsc_div
  import cbsc_pkg::*;
#(
  parameter int AW = 8,
  parameter int DW = 8,
  parameter int QB = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [AW-1:0] in_dividend,
  input  logic [DW-1:0] in_divisor,
  input  meta_t         in_meta,
  output logic          out_valid,
  output logic [QB:0]   out_quot,
  output meta_t         out_meta
);

  logic [DW-1:0] rem_s  [QB+1];
  logic [QB-1:0] low_s  [QB+1];
  logic [QB-1:0] quo_s  [QB+1];
  logic [DW-1:0] dvs_s  [QB+1];
  meta_t         meta_s [QB+1];
  logic          vld_s  [QB+1];
  logic          up;

  assign rem_s[0]  = DW'(in_dividend[AW-1:QB]);
  assign low_s[0]  = in_dividend[QB-1:0];
  assign quo_s[0]  = '0;
  assign dvs_s[0]  = in_divisor;
  assign meta_s[0] = in_meta;
  assign vld_s[0]  = in_valid;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DW:0] trial;
    logic        fits;
    assign trial = {rem_s[k], low_s[k][QB-1]};
    assign fits  = (trial >= {1'b0, dvs_s[k]});
    always_ff @(posedge clk) begin
      if (rst) vld_s[k+1] <= 1'b0;
      else if (en) vld_s[k+1] <= vld_s[k];
      if (en) begin
        rem_s[k+1]  <= fits ? DW'(trial - {1'b0, dvs_s[k]}) : DW'(trial);
        low_s[k+1]  <= {low_s[k][QB-2:0], 1'b0};
        quo_s[k+1]  <= {quo_s[k][QB-2:0], fits};
        dvs_s[k+1]  <= dvs_s[k];
        meta_s[k+1] <= meta_s[k];
      end
    end
  end

  assign up = (rem_s[QB] >= (dvs_s[QB] - rem_s[QB]));

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vld_s[QB];
    if (en) begin
      out_quot <= {1'b0, quo_s[QB]} + (QB + 1)'(up);
      out_meta <= meta_s[QB];
    end
  end

endmodule

[design/cbsc_outbuf.sv]
// Output stage: applies sign and saturation, then holds results in a two-entry
// buffer that decouples the result channel from the pipeline. Depends on cbsc_pkg.
`timescale 1ns / 1ps

module cbsc_outbuf
  import cbsc_pkg::*;
#(
  parameter int CW = 48,
  parameter int QW = 57
) (
  input  logic          clk,
  input  logic          rst,
  output logic          space,
  input  logic          in_valid,
  input  logic [QW-1:0] in_quot,
  input  meta_t         in_meta,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [CW-1:0] out_value,
  output logic          out_group,
  output logic [IDX_W-1:0] out_idx,
  output logic          out_sat,
  output logic          out_last
);

  localparam int XW = imax(QW, CW) + 1;
  localparam logic [XW-1:0] LIM = XW'(1) << (CW - 1);
  localparam int EW = CW + IDX_W + 3;

  logic [XW-1:0] qx;
  logic          sat;
  logic [CW-1:0] val;
  logic [EW-1:0] ent0, ent1, ent_new;
  logic [1:0]    count;
  logic          push, pop;

  always_comb begin
    qx = XW'(in_quot);
    if (in_meta.neg) begin
      sat = (qx > LIM);
      val = CW'(XW'(0) - (sat ? LIM : qx));
    end else begin
      sat = (qx > LIM - XW'(1));
      val = CW'(sat ? LIM - XW'(1) : qx);
    end
  end

  assign ent_new = {in_meta.last, sat, in_meta.idx, in_meta.group, val};
  assign space   = (count != 2'd2);
  assign push    = in_valid & space;
  assign pop     = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
    end
    if (push && pop) begin
      if (count == 2'd1) ent0 <= ent_new;
      else begin
        ent0 <= ent1;
        ent1 <= ent_new;
      end
    end else if (push) begin
      if (count == 2'd0) ent0 <= ent_new;
      else ent1 <= ent_new;
    end else if (pop) begin
      ent0 <= ent1;
    end
  end

  assign out_valid = (count != 2'd0);
  assign out_value = ent0[CW-1:0];
  assign out_group = ent0[CW];
  assign out_idx   = ent0[CW+IDX_W:CW+1];
  assign out_sat   = ent0[CW+IDX_W+1];
  assign out_last  = ent0[CW+IDX_W+2];

endmodule

[design/cbsc_checker.sv]
// Port-level checker for the stencil coefficient block, bound to the top level.
// Depends on cbsc_pkg and cut_cell_boundary_stencil_coeffs.
`timescale 1ns / 1ps

module cbsc_checker
  import cbsc_pkg::*;
#(
  parameter int COEF_WIDTH = 48,
  localparam int TDW = ((COEF_WIDTH + IDX_W + 7) / 8) * 8
) (
  input logic           clk,
  input logic           rst,
  input logic           m_tvalid,
  input logic           m_tready,
  input logic [TDW-1:0] m_tdata,
  input logic [1:0]     m_tuser,
  input logic           m_tlast
);

  localparam logic [COEF_WIDTH-1:0] VMAX = {1'b0, {(COEF_WIDTH - 1){1'b1}}};
  localparam logic [COEF_WIDTH-1:0] VMIN = {1'b1, {(COEF_WIDTH - 1){1'b0}}};

  // A stalled transaction holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // A clamped value sits at one of the two limits.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |->
      (m_tdata[COEF_WIDTH-1:0] == VMAX || m_tdata[COEF_WIDTH-1:0] == VMIN))
    else $error("saturated flag without a limit value");

  // Flux coefficients carry index 0 or 1, and the one with index 1 closes the run.
  a_flux: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      m_tdata[COEF_WIDTH+IDX_W-1:COEF_WIDTH+1] == '0 && (m_tlast == m_tdata[COEF_WIDTH]))
    else $error("bad flux index or run end");

  // Reset empties the result channel.
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind cut_cell_boundary_stencil_coeffs cbsc_checker #(.COEF_WIDTH(COEF_WIDTH)) u_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

[verif/cut_cell_boundary_stencil_coeffs_test.sv]
// Self-checking testbench for cut_cell_boundary_stencil_coeffs.
// Depends on cbsc_pkg and the block itself. A predictor built into the bench
// computes the expected coefficients, and every master-side transaction is checked.
`timescale 1ns / 1ps

module cut_cell_boundary_stencil_coeffs_test
  import cbsc_pkg::*;
();

  localparam int FB   = 16;
  localparam int CW   = 48;
  localparam int TDW  = ((CW + IDX_W + 7) / 8) * 8;
  localparam int SETTLE = 4 * FB + 39 + 20;   // pipeline latency plus margin
  localparam longint ONE_E = longint'(1) <<< (2 * FB);

  typedef struct packed {
    logic [CW-1:0]    value;
    logic             group;
    logic [IDX_W-1:0] idx;
    logic             sat;
    logic             last;
  } coef_t;

  typedef struct {
    logic [PW-1:0] psi;
    kind_t         kind;
    logic          right;
    bit            has_first;   // first coefficient typed in below
    logic [CW-1:0] first;
    int            count;       // number of coefficients the item yields
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [GW-1:0] cfg_wdata = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [TDW-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;

  cut_cell_boundary_stencil_coeffs #(.FRAC_BITS(FB), .COEF_WIDTH(CW)) dut (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  always #6 clk = ~clk;

  coef_t pending_coefs[$];
  coef_t last_run[$];
  logic [GW-1:0] spacing = SPACING_RESET;
  int errors = 0;
  int burst_left = 0;
  int items_sent = 0;

  // Rounded division of a * 2^s by d, ties upward; clamps to cap and flags it.
  function automatic logic [63:0] div_round(input logic [63:0] a, input int s,
                                            input logic [63:0] d, input logic [63:0] cap,
                                            output bit ovf);
    logic [127:0] num, q, r, dd;
    num = {64'd0, a} << s;
    dd = {64'd0, d};
    q = num / dd;
    r = num % dd;
    if (r >= dd - r) q = q + 1;
    ovf = (q > {64'd0, cap});
    return ovf ? cap : q[63:0];
  endfunction

  function automatic longint base_quot(input longint n, input int s, input logic [63:0] d);
    bit o;
    logic [63:0] m, q;
    m = (n < 0) ? -n : n;
    q = div_round(m, s, d, 64'd1 << 62, o);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic coef_t scale_coef(input longint v, input int s, input logic [63:0] d,
                                       input logic grp, input int idx, input bit last);
    coef_t c;
    bit ovf, sat;
    logic [63:0] lim, m, q;
    lim = 64'd1 << (CW - 1);
    m = (v < 0) ? -v : v;
    q = div_round(m, s, d, lim, ovf);
    sat = 0;
    if (v < 0) begin
      if (ovf) begin q = lim; sat = 1; end
      q = -q;
    end else if (ovf || q > lim - 1) begin
      q = lim - 1;
      sat = 1;
    end
    c.value = q[CW-1:0];
    c.group = grp;
    c.idx = idx[IDX_W-1:0];
    c.sat = sat;
    c.last = last;
    return c;
  endfunction

  // Builds the coefficient run for one item into last_run and appends it to
  // pending_coefs.
  task automatic predict_coefs(input logic [PW-1:0] p_raw, input kind_t kind,
                               input logic right);
    longint p, psi, psi2, psi3, c[8], x[2];
    logic [63:0] g, g2, pu;
    int nc, nx;
    last_run.delete();
    p = longint'(p_raw);
    pu = p;
    g = (spacing == 0) ? 64'd1 : 64'(spacing);
    g2 = g * g;
    psi = p <<< FB;
    psi2 = p * p;
    psi3 = longint'((pu * pu * pu + (64'd1 << (FB - 1))) >> FB);
    nx = 0;
    nc = 8;
    case (kind)
      KIND_FLOAT, KIND_DIRICHLET: begin
        c[0] = psi;
        c[1] = base_quot(2*ONE_E - 2*psi - 3*psi2 - psi3, 0, 2);
        c[2] = -2*ONE_E + 2*psi2 + psi3;
        c[3] = base_quot(2*ONE_E - psi2 - psi3, 0, 2);
        c[4] = base_quot(2*ONE_E + 4*psi, 2*FB, 2*ONE_E + 3*psi + psi2);
        c[5] = -2*psi;
        c[6] = base_quot(-2*ONE_E + 4*psi2, 2*FB, ONE_E + psi);
        c[7] = base_quot(2*ONE_E - 2*psi2, 2*FB, 2*ONE_E + psi);
        if (kind == KIND_DIRICHLET) begin
          for (int i = 0; i < 4; i++) c[i] = c[i+4];
          nc = 4;
        end
      end
      KIND_NEUMANN: begin
        c[0] = -base_quot(4*ONE_E + 8*psi, 2*FB, 2*ONE_E + 3*psi + psi2);
        c[1] = 2*psi;
        c[2] = base_quot(2*ONE_E + 2*psi - 4*psi2, 2*FB, ONE_E + psi);
        c[3] = base_quot(2*p*(p - (longint'(1) <<< FB)), 2*FB, 2*ONE_E + psi);
        c[4] = psi;
        c[5] = base_quot(-4*ONE_E - psi3 + psi2, 0, 2);
        c[6] = 2*ONE_E + psi3 - 2*psi2;
        c[7] = -base_quot(2*psi - 3*psi2 + psi3, 0, 2);
        x[0] = -2*ONE_E;
        x[1] = 2*(psi - ONE_E);
        nx = 2;
      end
      default: return;
    endcase
    for (int i = 0; i < nc; i++)
      last_run.push_back(scale_coef(right ? c[nc-1-i] : c[i], FB, g2, GROUP_STENCIL,
                                    i, nx == 0 && i == nc - 1));
    for (int i = 0; i < nx; i++)
      last_run.push_back(scale_coef(right ? -x[nx-1-i] : x[i], 0, g, GROUP_FLUX,
                                    i, i == nx - 1));
    foreach (last_run[k]) pending_coefs.push_back(last_run[k]);
  endtask

  // Offers one item and returns once its transaction has been accepted.
  // Bursts of random length are separated by random gaps.
  task automatic send_item(input logic [PW-1:0] psi, input kind_t kind, input logic right);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    items_sent++;
    s_tvalid <= 1;
    s_tdata <= {7'd0, psi};
    s_tuser <= {right, kind};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_coefs(psi, kind, right);
  endtask

  // Drains all outstanding results and writes the spacing register.
  task automatic set_spacing(input logic [GW-1:0] val);
    s_tvalid <= 0;
    burst_left = 0;
    while (pending_coefs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    spacing = val;
  endtask

  task automatic random_items(input int n);
    logic [PW-1:0] psi;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: psi = PW'($urandom_range(65537, 131071));   // psi beyond one
        1: psi = ($urandom_range(0, 1) != 0) ? 17'd0 : 17'd65536;
        default: psi = PW'($urandom_range(0, 65536));
      endcase
      send_item(psi, kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Receiver: random stalls, stretches of full readiness, and one long hold-off
  // while the sender keeps offering items so that the input side backs up.
  int rx_cycle = 0;
  int hold_left = 0;
  bit hold_started = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (!hold_started && items_sent >= 80) begin
      hold_started <= 1;
      hold_left <= 400;
      m_tready <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= (hold_left == 1);
    end else if (rx_cycle[8:7] == 2'd0) begin
      m_tready <= 1;
    end else begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Every accepted coefficient is matched against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      coef_t got, want;
      got.value = m_tdata[CW-1:0];
      got.idx = m_tdata[CW+IDX_W-1:CW];
      got.group = m_tuser[0];
      got.sat = m_tuser[1];
      got.last = m_tlast;
      if (pending_coefs.size() == 0) begin
        $display("%0t: unexpected coefficient %h", $time, got);
        errors++;
      end else begin
        want = pending_coefs.pop_front();
        if (got.value !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, got.value);
          errors++;
        end
        if (got.group !== want.group) begin
          $display("%0t: group expected %b actual %b", $time, want.group, got.group);
          errors++;
        end
        if (got.idx !== want.idx) begin
          $display("%0t: index expected %0d actual %0d", $time, want.idx, got.idx);
          errors++;
        end
        if (got.sat !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    row_t rows[$];
    // Directed rows at h = 1.0. The first coefficient is typed in where obvious:
    // floating left starts with psi itself, Dirichlet left with 2/2 = 1, and
    // Neumann right starts with the last Neumann stencil term, which is zero at
    // psi 0 and at psi 1.
    rows = '{
      '{17'd0,      KIND_FLOAT,     1'b0, 1, 48'd0,                  8},
      '{17'd65536,  KIND_FLOAT,     1'b0, 1, 48'd65536,              8},
      '{17'd131071, KIND_FLOAT,     1'b0, 1, 48'd131071,             8},
      '{17'd1,      KIND_FLOAT,     1'b1, 0, 48'd0,                  8},
      '{17'd32768,  KIND_FLOAT,     1'b1, 0, 48'd0,                  8},
      '{17'd0,      KIND_DIRICHLET, 1'b0, 1, 48'd65536,              4},
      '{17'd65536,  KIND_DIRICHLET, 1'b1, 0, 48'd0,                  4},
      '{17'd131071, KIND_DIRICHLET, 1'b0, 0, 48'd0,                  4},
      '{17'd0,      KIND_NEUMANN,   1'b1, 1, 48'd0,                  10},
      '{17'd65536,  KIND_NEUMANN,   1'b1, 1, 48'd0,                  10},
      '{17'd131071, KIND_NEUMANN,   1'b0, 0, 48'd0,                  10},
      '{17'd21845,  KIND_NEUMANN,   1'b0, 0, 48'd0,                  10},
      '{17'd40000,  KIND_UNUSED,    1'b0, 0, 48'd0,                  0},
      '{17'd131071, KIND_UNUSED,    1'b1, 0, 48'd0,                  0},
      '{17'd7,      KIND_FLOAT,     1'b0, 1, 48'd7,                  8}
    };

    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[i]) begin
      send_item(rows[i].psi, rows[i].kind, rows[i].right);
      if (last_run.size() != rows[i].count) begin
        $display("%0t: row %0d run length expected %0d actual %0d", $time, i,
                 rows[i].count, last_run.size());
        errors++;
      end
      if (rows[i].has_first && last_run[0].value !== rows[i].first) begin
        $display("%0t: row %0d first coefficient expected %h actual %h", $time, i,
                 rows[i].first, last_run[0].value);
        errors++;
      end
    end
    random_items(60);

    // Smallest spacing drives most coefficients into saturation.
    set_spacing(24'd1);
    random_items(35);
    set_spacing(24'hFFFFFF);
    random_items(35);
    // A zero spacing is treated as the smallest one.
    set_spacing(24'd0);
    random_items(25);
    set_spacing(GW'($urandom_range(256, 16777215)));
    random_items(35);

    s_tvalid <= 0;
    while (pending_coefs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
